// ===== rtl/grid_ray_dda_traversal_defines.svh =====
// assertion macros for the grid ray walker
`ifndef GRID_RAY_DDA_TRAVERSAL_DEFINES_SVH
`define GRID_RAY_DDA_TRAVERSAL_DEFINES_SVH

// same-cycle implication
`define GRDT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GRDT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/grdt_pkg.sv =====
// types and constants shared by the grid ray walker modules
package grdt_pkg;

   localparam int unsigned DIV_STEPS = 31;
   localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   localparam logic SIDE_X = 1'b0;
   localparam logic SIDE_Y = 1'b1;

   typedef struct packed {
      logic               action;
      logic        [23:0] origin_x;
      logic        [23:0] origin_y;
      logic signed [15:0] direction_x;
      logic signed [15:0] direction_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] cell_x;
      logic signed [15:0] cell_y;
      logic               crossed_side;
      logic signed [31:0] hit_x;
      logic signed [31:0] hit_y;
      logic               hit_valid;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_DELTA,
      ST_MUL_X,
      ST_MUL_Y,
      ST_STEP_MUL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load_ray;
      logic step_t;
      logic div_step;
      logic load_delta;
      logic mul_x;
      logic mul_y;
      logic step_mul;
      logic load_rsp;
      logic rsp_is_step;
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
   } dp_status_type;

endpackage

// ===== rtl/grdt_ctrl.sv =====
// sequencer for ray start and step requests
`include "grid_ray_dda_traversal_defines.svh"

module grdt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_action,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output grdt_pkg::dp_cmd_type   cmd,
   input  grdt_pkg::dp_status_type status
);

   grdt_pkg::state_type state_ff, state_in;
   logic                step_mode_ff, step_mode_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= grdt_pkg::ST_IDLE;
         step_mode_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_mode_ff <= step_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_mode_in = step_mode_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         grdt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action == grdt_pkg::ACT_STEP) begin
                  cmd.step_t   = 1'b1;
                  step_mode_in = 1'b1;
                  state_in     = grdt_pkg::ST_STEP_MUL;
               end else begin
                  cmd.load_ray = 1'b1;
                  step_mode_in = 1'b0;
                  state_in     = grdt_pkg::ST_DIV;
               end
            end
         end
         grdt_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = grdt_pkg::ST_DELTA;
            end
         end
         grdt_pkg::ST_DELTA: begin
            cmd.load_delta = 1'b1;
            state_in       = grdt_pkg::ST_MUL_X;
         end
         grdt_pkg::ST_MUL_X: begin
            cmd.mul_x = 1'b1;
            state_in  = grdt_pkg::ST_MUL_Y;
         end
         grdt_pkg::ST_MUL_Y: begin
            cmd.mul_y = 1'b1;
            state_in  = grdt_pkg::ST_FINISH;
         end
         grdt_pkg::ST_STEP_MUL: begin
            cmd.step_mul = 1'b1;
            state_in     = grdt_pkg::ST_FINISH;
         end
         grdt_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp    = 1'b1;
               cmd.rsp_is_step = step_mode_ff;
               state_in        = grdt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = grdt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `GRDT_ASSERT_NXT(a_start_enters_div, clock, reset,
      req_valid && req_ready && (req_action == grdt_pkg::ACT_START),
      state_ff == grdt_pkg::ST_DIV, "start request did not begin the divide")
   `GRDT_ASSERT_NXT(a_div_ends, clock, reset,
      (state_ff == grdt_pkg::ST_DIV) && status.div_last,
      state_ff == grdt_pkg::ST_DELTA, "divide did not end on its last step")
   `GRDT_ASSERT_IMP(a_no_overwrite, clock, reset,
      cmd.load_rsp, !rsp_valid_ff || rsp_ready, "pending response overwritten")

endmodule

// ===== rtl/grdt_datapath.sv =====
// ray state, reciprocal divider, shared multiplier and response register
`include "grid_ray_dda_traversal_defines.svh"

module grdt_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  grdt_pkg::req_type       req_data,
   input  grdt_pkg::dp_cmd_type    cmd,
   output grdt_pkg::dp_status_type status,
   output grdt_pkg::rsp_type       rsp_data
);

   // ray state
   logic [23:0] origin_x_ff, origin_x_in, origin_y_ff, origin_y_in;
   logic [15:0] dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic [31:0] delta_x_ff, delta_x_in, delta_y_ff, delta_y_in;
   logic [31:0] side_x_ff, side_x_in, side_y_ff, side_y_in;
   logic [15:0] cell_x_ff, cell_x_in, cell_y_ff, cell_y_in;
   logic        last_side_ff, last_side_in;

   // divider
   logic [grdt_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [16:0] mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic [16:0] rem_x_ff, rem_x_in, rem_y_ff, rem_y_in;
   logic [30:0] quo_x_ff, quo_x_in, quo_y_ff, quo_y_in;
   logic [30:0] num_ff, num_in;

   // multiplier and step
   logic signed [50:0] prod_ff, prod_in;
   logic        [31:0] t_ff, t_in;
   grdt_pkg::rsp_type  rsp_ff, rsp_in;

   logic        [17:0] shx, shy;
   logic               gex, gey;
   logic        [16:0] fx, fy;
   logic signed [32:0] mul_a;
   logic signed [17:0] mul_b;
   logic               move_x;
   logic        [31:0] sel_side, sel_delta, sat_side;
   logic        [32:0] sum_side;
   logic        [15:0] sel_dir;
   logic        [15:0] cell_step_x, cell_step_y;
   logic signed [36:0] quot;
   logic signed [37:0] along_sum;
   logic        [31:0] along;
   logic        [23:0] along_origin;
   logic        [15:0] wall_cell, wall_dir;
   logic        [31:0] wall;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         dir_x_ff     <= '0;
         dir_y_ff     <= '0;
         delta_x_ff   <= '0;
         delta_y_ff   <= '0;
         side_x_ff    <= '0;
         side_y_ff    <= '0;
         cell_x_ff    <= '0;
         cell_y_ff    <= '0;
         last_side_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         origin_x_ff  <= origin_x_in;
         origin_y_ff  <= origin_y_in;
         dir_x_ff     <= dir_x_in;
         dir_y_ff     <= dir_y_in;
         delta_x_ff   <= delta_x_in;
         delta_y_ff   <= delta_y_in;
         side_x_ff    <= side_x_in;
         side_y_ff    <= side_y_in;
         cell_x_ff    <= cell_x_in;
         cell_y_ff    <= cell_y_in;
         last_side_ff <= last_side_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_x_ff <= mag_x_in;
      mag_y_ff <= mag_y_in;
      rem_x_ff <= rem_x_in;
      rem_y_ff <= rem_y_in;
      quo_x_ff <= quo_x_in;
      quo_y_ff <= quo_y_in;
      num_ff   <= num_in;
      prod_ff  <= prod_in;
      t_ff     <= t_in;
      rsp_ff   <= rsp_in;
   end

   // restoring divide step, both axes together
   assign shx = {rem_x_ff, num_ff[30]};
   assign shy = {rem_y_ff, num_ff[30]};
   assign gex = shx >= {1'b0, mag_x_ff};
   assign gey = shy >= {1'b0, mag_y_ff};

   // distance to the first grid line, Q0.16 with 1.0 included
   assign fx = dir_x_ff[15] ? {1'b0, origin_x_ff[15:0]} : (17'h10000 - {1'b0, origin_x_ff[15:0]});
   assign fy = dir_y_ff[15] ? {1'b0, origin_y_ff[15:0]} : (17'h10000 - {1'b0, origin_y_ff[15:0]});

   // step selection
   assign move_x    = side_x_ff < side_y_ff;
   assign sel_side  = move_x ? side_x_ff : side_y_ff;
   assign sel_delta = move_x ? delta_x_ff : delta_y_ff;
   assign sum_side  = {1'b0, sel_side} + {1'b0, sel_delta};
   assign sat_side  = sum_side[32] ? 32'hFFFF_FFFF : sum_side[31:0];
   assign cell_step_x = cell_x_ff + (dir_x_ff[15] ? 16'hFFFF : 16'd1);
   assign cell_step_y = cell_y_ff + (dir_y_ff[15] ? 16'hFFFF : 16'd1);

   // shared multiplier operands
   assign sel_dir = (last_side_ff == grdt_pkg::SIDE_X) ? dir_y_ff : dir_x_ff;
   always_comb begin
      if (cmd.mul_x) begin
         mul_a = signed'({1'b0, delta_x_ff});
         mul_b = signed'({1'b0, fx});
      end else if (cmd.mul_y) begin
         mul_a = signed'({1'b0, delta_y_ff});
         mul_b = signed'({1'b0, fy});
      end else begin
         mul_a = signed'({1'b0, t_ff});
         mul_b = signed'({{2{sel_dir[15]}}, sel_dir});
      end
   end

   // hit point along the crossed wall, floored and saturated
   assign quot         = prod_ff[50:14];
   assign along_origin = (last_side_ff == grdt_pkg::SIDE_X) ? origin_y_ff : origin_x_ff;
   assign along_sum    = signed'({14'd0, along_origin}) + 38'(quot);
   always_comb begin
      if (!along_sum[37] && (along_sum[36:31] != 6'd0)) begin
         along = 32'h7FFF_FFFF;
      end else if (along_sum[37] && (along_sum[36:31] != 6'h3F)) begin
         along = 32'h8000_0000;
      end else begin
         along = along_sum[31:0];
      end
   end
   assign wall_cell = (last_side_ff == grdt_pkg::SIDE_X) ? cell_x_ff : cell_y_ff;
   assign wall_dir  = (last_side_ff == grdt_pkg::SIDE_X) ? dir_x_ff : dir_y_ff;
   assign wall      = {wall_cell + {15'd0, wall_dir[15]}, 16'd0};

   always_comb begin
      origin_x_in  = origin_x_ff;
      origin_y_in  = origin_y_ff;
      dir_x_in     = dir_x_ff;
      dir_y_in     = dir_y_ff;
      delta_x_in   = delta_x_ff;
      delta_y_in   = delta_y_ff;
      side_x_in    = side_x_ff;
      side_y_in    = side_y_ff;
      cell_x_in    = cell_x_ff;
      cell_y_in    = cell_y_ff;
      last_side_in = last_side_ff;
      cnt_in       = cnt_ff;
      mag_x_in     = mag_x_ff;
      mag_y_in     = mag_y_ff;
      rem_x_in     = rem_x_ff;
      rem_y_in     = rem_y_ff;
      quo_x_in     = quo_x_ff;
      quo_y_in     = quo_y_ff;
      num_in       = num_ff;
      prod_in      = prod_ff;
      t_in         = t_ff;
      rsp_in       = rsp_ff;

      if (cmd.load_ray) begin
         origin_x_in  = req_data.origin_x;
         origin_y_in  = req_data.origin_y;
         dir_x_in     = req_data.direction_x;
         dir_y_in     = req_data.direction_y;
         cell_x_in    = {8'd0, req_data.origin_x[23:16]};
         cell_y_in    = {8'd0, req_data.origin_y[23:16]};
         last_side_in = grdt_pkg::SIDE_X;
         cnt_in       = '0;
         mag_x_in     = 17'h10000 - {1'b0, req_data.direction_x};
         mag_y_in     = 17'h10000 - {1'b0, req_data.direction_y};
         if (!req_data.direction_x[15]) begin
            mag_x_in = {1'b0, req_data.direction_x};
         end
         if (!req_data.direction_y[15]) begin
            mag_y_in = {1'b0, req_data.direction_y};
         end
         rem_x_in     = '0;
         rem_y_in     = '0;
         num_in       = 31'h4000_0000;
      end

      if (cmd.div_step) begin
         cnt_in   = cnt_ff + 1'b1;
         num_in   = {num_ff[29:0], 1'b0};
         rem_x_in = gex ? 17'(shx - {1'b0, mag_x_ff}) : shx[16:0];
         rem_y_in = gey ? 17'(shy - {1'b0, mag_y_ff}) : shy[16:0];
         quo_x_in = {quo_x_ff[29:0], gex};
         quo_y_in = {quo_y_ff[29:0], gey};
      end

      if (cmd.load_delta) begin
         delta_x_in = (mag_x_ff == 17'd0) ? 32'hFFFF_FFFF : {1'b0, quo_x_ff};
         delta_y_in = (mag_y_ff == 17'd0) ? 32'hFFFF_FFFF : {1'b0, quo_y_ff};
      end

      if (cmd.mul_x || cmd.mul_y || cmd.step_mul) begin
         prod_in = mul_a * mul_b;
      end
      if (cmd.mul_y) begin
         side_x_in = prod_ff[47:16];
      end

      if (cmd.step_t) begin
         if (move_x) begin
            cell_x_in    = cell_step_x;
            side_x_in    = sat_side;
            last_side_in = grdt_pkg::SIDE_X;
         end else begin
            cell_y_in    = cell_step_y;
            side_y_in    = sat_side;
            last_side_in = grdt_pkg::SIDE_Y;
         end
         t_in = sat_side - sel_delta;
      end

      if (cmd.load_rsp) begin
         rsp_in.cell_x       = cell_x_ff;
         rsp_in.cell_y       = cell_y_ff;
         rsp_in.crossed_side = last_side_ff;
         if (cmd.rsp_is_step) begin
            rsp_in.hit_valid = 1'b1;
            if (last_side_ff == grdt_pkg::SIDE_X) begin
               rsp_in.hit_x = wall;
               rsp_in.hit_y = along;
            end else begin
               rsp_in.hit_x = along;
               rsp_in.hit_y = wall;
            end
         end else begin
            side_y_in        = prod_ff[47:16];
            rsp_in.hit_valid = 1'b0;
            rsp_in.hit_x     = {8'd0, origin_x_ff};
            rsp_in.hit_y     = {8'd0, origin_y_ff};
         end
      end
   end

   assign status.div_last = cnt_ff == grdt_pkg::CNT_W'(grdt_pkg::DIV_STEPS - 1);
   assign rsp_data        = rsp_ff;

   `GRDT_ASSERT_NXT(a_delta_nonzero, clock, reset,
      cmd.load_delta, (delta_x_ff != 32'd0) && (delta_y_ff != 32'd0),
      "reciprocal came out zero")
   `GRDT_ASSERT_NXT(a_step_one_axis, clock, reset,
      cmd.step_t,
      (cell_x_ff != $past(cell_x_ff)) != (cell_y_ff != $past(cell_y_ff)),
      "step did not move exactly one axis")

endmodule

// ===== rtl/grid_ray_dda_traversal.sv =====
// 2d grid ray walker: start loads a ray, each step crosses one grid wall.
// a step request goes from acceptance to response through select and
// saturating add, multiply, and hit add and saturate; the last of these
// waits while an earlier response is pending and not taken. the next
// request is taken after that response is loaded. a start request runs
// the bit-serial reciprocal divider (both axes in parallel), latches the
// deltas, makes two passes through the shared multiplier for the first
// side distances, and then loads and offers the response. a finished
// response waits in an output register and the next request is taken while it waits.
module grid_ray_dda_traversal (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  grdt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output grdt_pkg::rsp_type rsp_data
);

   grdt_pkg::dp_cmd_type    cmd;
   grdt_pkg::dp_status_type status;

   grdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_action (req_data.action),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status)
   );

   grdt_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
